>>> design/gsm7_septet_unpacker_macros.svh
// assertion helpers for the gsm7 septet unpacker checker
`ifndef GSM7_SEPTET_UNPACKER_MACROS_SVH
`define GSM7_SEPTET_UNPACKER_MACROS_SVH

// concurrent assertion on a given clock and active-low reset
`define GSM7_ASSERT_CR(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("gsm7 unpacker check failed");

// same, on the block's own clock and reset
`define GSM7_ASSERT(label, prop) \
  `GSM7_ASSERT_CR(label, clk_i, rst_ni, prop)

`endif

>>> design/gsm7_pkg.sv
package gsm7_pkg;

  localparam logic [6:0] EscCode = 7'h1b;
  localparam logic [7:0] QMark   = 8'h3f;

  // one decoded result word
  typedef struct packed {
    logic [7:0] code;
    logic       cvalid;
    logic       last;
  } res_t;

  // up to two results produced by one byte, in order
  typedef struct packed {
    logic [1:0] n;
    res_t       first;
    res_t       second;
  } push_t;

  // outcome of one septet
  typedef struct packed {
    logic emit;
    res_t res;
    logic esc;
  } sdec_t;

  // default alphabet, latin-1 codes
  localparam logic [7:0] GSM_ROM [128] = '{
    8'h40, 8'ha3, 8'h24, 8'ha5, 8'he8, 8'he9, 8'hf9, 8'hec,
    8'hf2, 8'hc7, 8'h0a, 8'hd8, 8'hf8, 8'h0d, 8'hc5, 8'he5,
    8'h3f, 8'h5f, 8'h3f, 8'h3f, 8'h3f, 8'h3f, 8'h3f, 8'h3f,
    8'h3f, 8'h3f, 8'h3f, 8'h3f, 8'hc6, 8'he6, 8'hdf, 8'hc9,
    8'h20, 8'h21, 8'h22, 8'h23, 8'ha4, 8'h25, 8'h26, 8'h27,
    8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f,
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f,
    8'ha1, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
    8'h48, 8'h49, 8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h4f,
    8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57,
    8'h58, 8'h59, 8'h5a, 8'hc4, 8'hd6, 8'hd1, 8'hdc, 8'ha7,
    8'hbf, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
    8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f,
    8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
    8'h78, 8'h79, 8'h7a, 8'he4, 8'hf6, 8'hf1, 8'hfc, 8'he0
  };

  // extension table, unknown codes give a question mark
  function automatic logic [7:0] ext_code(logic [6:0] s);
    logic [7:0] c;
    begin
      unique case (s)
        7'h0a:   c = 8'h0a;
        7'h14:   c = 8'h5e;
        7'h28:   c = 8'h7b;
        7'h29:   c = 8'h7d;
        7'h2f:   c = 8'h5c;
        7'h3c:   c = 8'h5b;
        7'h3d:   c = 8'h7e;
        7'h3e:   c = 8'h5d;
        7'h40:   c = 8'h7c;
        default: c = QMark;
      endcase
      return c;
    end
  endfunction

  function automatic sdec_t dec_septet(logic [6:0] s, logic esc, logic last);
    sdec_t d;
    begin
      d.emit       = 1'b1;
      d.esc        = 1'b0;
      d.res.cvalid = 1'b1;
      d.res.last   = last;
      if (esc) begin
        d.res.code = ext_code(s);
      end else if (s == EscCode) begin
        // escape gives a bare end marker only when it closes the message
        d.res.code   = 8'h00;
        d.res.cvalid = 1'b0;
        d.emit       = last;
        d.esc        = !last;
      end else begin
        d.res.code = GSM_ROM[s];
      end
      return d;
    end
  endfunction

endpackage

>>> design/gsm7_septet_unpacker.sv
// gsm 7-bit default alphabet unpacker. each input word carries one packed byte
// (lsb first) and, on the first byte of a message, the septet count; each output
// word is one decoded latin-1 character, or a bare end marker (tuser low, code 0)
// when a message ends on an escape. a byte yields zero, one or two words; tlast
// marks the word that uses up the count, and bytes after that give nothing.
// an input word is taken every cycle as long as the output side keeps up; since
// the output moves one word per cycle, a byte that completes two septets
// (every seventh byte) holds the input until its second word is popped. the
// path from input to output word is an input register, then decode into a
// two-entry result buffer.
module gsm7_septet_unpacker import gsm7_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] packed_byte, [15:8] septet_count
  input  logic        s_axis_tuser,  // [0] message_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] char_code
  output logic        m_axis_tuser,  // [0] char_valid
  output logic        m_axis_tlast   // last_of_message
);

  // input register stage
  logic       s0_vld_q;
  logic [7:0] s0_byte_q;
  logic       s0_start_q;
  logic [7:0] s0_count_q;

  logic  buf_free, move, pop, in_fire;
  push_t push;
  res_t  head;

  // the held byte moves into the result buffer once the buffer drains
  assign move          = s0_vld_q && buf_free;
  assign s_axis_tready = !s0_vld_q || move;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      s0_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_byte_q  <= s_axis_tdata[7:0];
      s0_count_q <= s_axis_tdata[15:8];
      s0_start_q <= s_axis_tuser;
    end
  end

  // septet split, escape tracking and table lookup
  gsm7_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (move),
    .packed_byte_i   (s0_byte_q),
    .message_start_i (s0_start_q),
    .septet_count_i  (s0_count_q),
    .push_o          (push)
  );

  // holds the one or two words of a byte and serializes them
  gsm7_outbuf u_outbuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_en_i (move),
    .push_i    (push),
    .pop_i     (pop),
    .free_o    (buf_free),
    .valid_o   (m_axis_tvalid),
    .head_o    (head)
  );

  assign m_axis_tdata = head.code;
  assign m_axis_tuser = head.cvalid;
  assign m_axis_tlast = head.last;

endmodule

>>> design/gsm7_decode.sv
module gsm7_decode import gsm7_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] packed_byte_i,
  input  logic       message_start_i,
  input  logic [7:0] septet_count_i,
  output push_t      push_o
);

  logic [6:0]  lb_q, lb_d, lb_e;
  logic [2:0]  lc_q, lc_d, lc_e;
  logic [7:0]  rem_q, rem_d, rem_e;
  logic        esc_q, esc_d, esc_e;
  logic [14:0] acc;
  logic        has, last0, last1, two, e0, e1;
  sdec_t       d0, d1;

  always_comb begin
    // a start clears the kept bits and escape before the byte is used
    lb_e  = message_start_i ? 7'd0 : lb_q;
    lc_e  = message_start_i ? 3'd0 : lc_q;
    esc_e = message_start_i ? 1'b0 : esc_q;
    rem_e = message_start_i ? septet_count_i : rem_q;

    acc   = 15'(lb_e) | (15'(packed_byte_i) << lc_e);
    has   = rem_e != 8'd0;
    last0 = rem_e == 8'd1;
    last1 = rem_e == 8'd2;
    two   = has && (lc_e == 3'd6) && !last0;

    d0 = dec_septet(acc[6:0], esc_e, last0);
    d1 = dec_septet(acc[13:7], d0.esc, last1);
    e0 = has && d0.emit;
    e1 = two && d1.emit;

    push_o.n      = 2'(e0) + 2'(e1);
    push_o.first  = e0 ? d0.res : d1.res;
    push_o.second = d1.res;

    rem_d = has ? (rem_e - (two ? 8'd2 : 8'd1)) : rem_e;
    if (rem_d == 8'd0) begin
      lb_d  = 7'd0;
      lc_d  = 3'd0;
      esc_d = 1'b0;
    end else if (two) begin
      lb_d  = 7'd0;
      lc_d  = 3'd0;
      esc_d = d1.esc;
    end else begin
      lb_d  = acc[13:7];
      lc_d  = lc_e + 3'd1;
      esc_d = d0.esc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lb_q  <= 7'd0;
      lc_q  <= 3'd0;
      rem_q <= 8'd0;
      esc_q <= 1'b0;
    end else if (en_i) begin
      lb_q  <= lb_d;
      lc_q  <= lc_d;
      rem_q <= rem_d;
      esc_q <= esc_d;
    end
  end

endmodule

>>> design/gsm7_outbuf.sv
module gsm7_outbuf import gsm7_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_en_i,
  input  push_t push_i,
  input  logic  pop_i,
  output logic  free_o,
  output logic  valid_o,
  output res_t  head_o
);

  logic [1:0] cnt_q, cnt_d;
  res_t       e0_q, e0_d, e1_q, e1_d;

  // a push always lands in a buffer that is empty after this cycle's pop
  assign free_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop_i);
  assign valid_o = cnt_q != 2'd0;
  assign head_o  = e0_q;

  always_comb begin
    cnt_d = cnt_q;
    e0_d  = e0_q;
    e1_d  = e1_q;
    if (pop_i) begin
      e0_d  = e1_q;
      cnt_d = cnt_q - 2'd1;
    end
    if (push_en_i) begin
      e0_d  = push_i.first;
      e1_d  = push_i.second;
      cnt_d = push_i.n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

endmodule

>>> design/gsm7_septet_unpacker_chk.sv
`include "gsm7_septet_unpacker_macros.svh"

module gsm7_septet_unpacker_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // full output word, code, flag and marker
  logic [9:0] out_word;

  assign out_word = {m_axis_tdata, m_axis_tuser, m_axis_tlast};

  // a stalled output word stays up
  `GSM7_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

  // and keeps its contents
  `GSM7_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(out_word))

  // a bare marker only closes a message and carries code zero
  `GSM7_ASSERT(a_marker_last, m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && !(|m_axis_tdata))

  // an ordinary character never decodes to code zero
  `GSM7_ASSERT(a_char_nonzero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata != 8'h00)

endmodule

bind gsm7_septet_unpacker gsm7_septet_unpacker_chk u_chk (.*);
